@@ design/fcca_pkg.sv @@
// Shared types and constants for the FAT cluster chain allocator.
`timescale 1ns / 1ps

package fcca_pkg;

    // Default table size
    localparam int NUM_CLUSTERS_DEF = 1024;

    // Fixed field widths of the request and result ports
    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_FORMAT = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_BROKEN    = 3'd3,
        ST_BAD       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_LAST,
        S_FREE_WALK,
        S_QUERY,
        S_RESP
    } state_t;

    // One result transaction
    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  cluster;
        logic                eoc;
        logic [FREE_W-1:0]   free_count;
    } res_t;

endpackage

@@ design/fat_cluster_chain_allocator.sv @@
// Top level of the FAT cluster chain allocator: request intake and result register.
//
//  channel   ports                                         direction
//  request   s_valid/s_ready, s_command, s_cluster_count,  in
//            s_cluster_index
//  result    m_valid/m_ready, m_status, m_cluster_out,     out
//            m_end_of_chain, m_free_count
//
// Sequence from request transaction to result transaction:
//   Allocate: scan one table entry per cycle, ending at the last cluster taken. Free:
//   walk the chain link by link. Query: read one entry. Format: clear every entry.
// Scans, walks and queries read the table, whose read data is registered.
// After reset a clearing pass marks every table entry free before s_ready rises.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module fat_cluster_chain_allocator #(
    parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fcca_pkg::CMD_W-1:0]      s_command,
    input  logic [fcca_pkg::COUNT_W-1:0]    s_cluster_count,
    input  logic [fcca_pkg::INDEX_W-1:0]    s_cluster_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fcca_pkg::STATUS_W-1:0]   m_status,
    output logic [fcca_pkg::INDEX_W-1:0]    m_cluster_out,
    output logic                            m_end_of_chain,
    output logic [fcca_pkg::FREE_W-1:0]     m_free_count
);
    import fcca_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;
    logic m_valid_reg, m_valid_next;
    res_t m_res_reg;

    fcca_core #(
        .NUM_CLUSTERS(NUM_CLUSTERS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req_command (s_command),
        .req_count   (s_cluster_count),
        .req_index   (s_cluster_index),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_res_reg.status;
    assign m_cluster_out  = m_res_reg.cluster;
    assign m_end_of_chain = m_res_reg.eoc;
    assign m_free_count   = m_res_reg.free_count;

endmodule

@@ design/fcca_core.sv @@
// Link table memory and the sequencer that allocates, frees, queries and formats it.
`timescale 1ns / 1ps

module fcca_core #(
    parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [fcca_pkg::CMD_W-1:0]     req_command,
    input  logic [fcca_pkg::COUNT_W-1:0]   req_count,
    input  logic [fcca_pkg::INDEX_W-1:0]   req_index,
    output logic                           res_valid,
    input  logic                           res_ready,
    output fcca_pkg::res_t                 res
);
    import fcca_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLUSTERS);
    localparam int ENT_W = $clog2(NUM_CLUSTERS + 2);
    localparam int CNT_W = $clog2(NUM_CLUSTERS + 1);

    // Entry encoding: below NUM_CLUSTERS is a link
    localparam logic [ENT_W-1:0] FREE_MARK = ENT_W'(NUM_CLUSTERS);
    localparam logic [ENT_W-1:0] EOC_MARK  = ENT_W'(NUM_CLUSTERS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CLUSTERS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NUM_CLUSTERS);

    // Link table
    logic [ENT_W-1:0] mem [NUM_CLUSTERS];
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [ENT_W-1:0] wd;
    logic             re;
    logic [IDX_W-1:0] ra;
    logic [ENT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rdata_reg <= mem[ra];
        end
    end

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             fmt_reg, fmt_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] addr_q_reg, addr_q_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0] want_reg, want_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             head_reg, head_next;
    logic             fwd_reg, fwd_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    status_t          st_reg, st_next;
    logic [ENT_W-1:0] cl_reg, cl_next;
    logic             eoc_reg, eoc_next;

    logic [ENT_W-1:0] rd_eff;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] taken_inc;
    logic             scan_in_range;

    // Same-cycle write and read of one entry in the free walk reads as free
    assign rd_eff        = fwd_reg ? FREE_MARK : rdata_reg;
    assign rd_idx        = IDX_W'(rd_eff);
    assign taken_inc     = taken_reg + CNT_W'(1);
    assign scan_in_range = {1'b0, scan_reg} < (IDX_W + 1)'(NUM_CLUSTERS);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            fmt_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            fwd_reg      <= 1'b0;
            free_cnt_reg <= FULL_CNT;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            fmt_reg      <= fmt_next;
            pend_reg     <= pend_next;
            fwd_reg      <= fwd_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        addr_q_reg <= addr_q_next;
        taken_reg  <= taken_next;
        want_reg   <= want_next;
        prev_reg   <= prev_next;
        first_reg  <= first_next;
        cur_reg    <= cur_next;
        head_reg   <= head_next;
        st_reg     <= st_next;
        cl_reg     <= cl_next;
        eoc_reg    <= eoc_next;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        fmt_next      = fmt_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        addr_q_next   = addr_q_reg;
        taken_next    = taken_reg;
        want_next     = want_reg;
        prev_next     = prev_reg;
        first_next    = first_reg;
        cur_next      = cur_reg;
        head_next     = head_reg;
        fwd_next      = 1'b0;
        free_cnt_next = free_cnt_reg;
        st_next       = st_reg;
        cl_next       = cl_reg;
        eoc_next      = eoc_reg;
        we            = 1'b0;
        wa            = '0;
        wd            = FREE_MARK;
        re            = 1'b0;
        ra            = '0;
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = FREE_MARK;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX) begin
                    clr_next      = '0;
                    free_cnt_next = FULL_CNT;
                    fmt_next      = 1'b0;
                    st_next       = ST_OK;
                    state_next    = fmt_reg ? S_RESP : S_IDLE;
                end
            end

            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    st_next  = ST_OK;
                    cl_next  = '0;
                    eoc_next = 1'b0;
                    unique case (cmd_t'(req_command))
                        CMD_ALLOC: begin
                            if (req_count == '0) begin
                                st_next    = ST_BAD;
                                state_next = S_RESP;
                            end else if (32'(req_count) > 32'(free_cnt_reg)) begin
                                st_next    = ST_NO_SPACE;
                                state_next = S_RESP;
                            end else begin
                                want_next  = CNT_W'(req_count);
                                taken_next = '0;
                                scan_next  = '0;
                                state_next = S_ALLOC_SCAN;
                            end
                        end
                        CMD_FREE, CMD_QUERY: begin
                            if (32'(req_index) >= NUM_CLUSTERS) begin
                                st_next    = ST_BAD;
                                state_next = S_RESP;
                            end else begin
                                re         = 1'b1;
                                ra         = IDX_W'(req_index);
                                cur_next   = IDX_W'(req_index);
                                head_next  = 1'b1;
                                state_next = (cmd_t'(req_command) == CMD_FREE) ?
                                             S_FREE_WALK : S_QUERY;
                            end
                        end
                        CMD_FORMAT: begin
                            clr_next   = '0;
                            fmt_next   = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // One read issued per cycle; data of the previous address is examined
            S_ALLOC_SCAN: begin
                if (scan_in_range) begin
                    re          = 1'b1;
                    ra          = scan_reg;
                    pend_next   = 1'b1;
                    addr_q_next = scan_reg;
                    scan_next   = scan_reg + IDX_W'(1);
                end
                if (pend_reg && rdata_reg == FREE_MARK) begin
                    if (taken_reg == '0) begin
                        first_next = addr_q_reg;
                    end else begin
                        we = 1'b1;
                        wa = prev_reg;
                        wd = ENT_W'(addr_q_reg);
                    end
                    prev_next  = addr_q_reg;
                    taken_next = taken_inc;
                    if (taken_inc == want_reg) begin
                        pend_next  = 1'b0;
                        state_next = S_ALLOC_LAST;
                    end
                end
            end

            S_ALLOC_LAST: begin
                we            = 1'b1;
                wa            = prev_reg;
                wd            = EOC_MARK;
                free_cnt_next = free_cnt_reg - want_reg;
                st_next       = ST_OK;
                cl_next       = ENT_W'(first_reg);
                state_next    = S_RESP;
            end

            // One link per cycle: free current entry, fetch the next one
            S_FREE_WALK: begin
                if (rd_eff == FREE_MARK) begin
                    st_next    = head_reg ? ST_NOT_ALLOC : ST_BROKEN;
                    state_next = S_RESP;
                end else begin
                    we            = 1'b1;
                    wa            = cur_reg;
                    wd            = FREE_MARK;
                    free_cnt_next = free_cnt_reg + CNT_W'(1);
                    head_next     = 1'b0;
                    if (rd_eff == EOC_MARK) begin
                        st_next    = ST_OK;
                        state_next = S_RESP;
                    end else if (rd_eff > FREE_MARK) begin
                        st_next    = ST_BROKEN;
                        state_next = S_RESP;
                    end else begin
                        re       = 1'b1;
                        ra       = rd_idx;
                        cur_next = rd_idx;
                        fwd_next = (rd_idx == cur_reg);
                    end
                end
            end

            S_QUERY: begin
                if (rd_eff == FREE_MARK) begin
                    st_next = ST_NOT_ALLOC;
                end else if (rd_eff == EOC_MARK) begin
                    eoc_next = 1'b1;
                end else begin
                    cl_next = rd_eff;
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status     = st_reg;
    assign res.cluster    = INDEX_W'(cl_reg);
    assign res.eoc        = eoc_reg;
    assign res.free_count = FREE_W'(free_cnt_reg);

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= FULL_CNT)
        else $error("free count above table size");

    a_scan_short: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ALLOC_SCAN |-> taken_reg < want_reg)
        else $error("allocation scan ran past requested length");

    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !we)
        else $error("link table written while idle");

    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ALLOC_LAST |=>
            free_cnt_reg == $past(free_cnt_reg) - $past(want_reg))
        else $error("free count not reduced by allocation size");

    a_res_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !req_ready)
        else $error("request taken while result pending");
`endif

endmodule
